/* hdl/eqlim_pkg.sv */
// shared types and constants of the stereo equalizer and limiter
package eqlim_pkg;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_COEF   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] CFG_BAND_EN  = 2'd0;
    localparam logic [1:0] CFG_COMP_EN  = 2'd1;
    localparam logic [1:0] CFG_PRE_GAIN = 2'd2;
    localparam logic [1:0] CFG_MAKEUP   = 2'd3;

    localparam logic [28:0] PRE_GAIN_RST = 29'd268435456;
    localparam logic [29:0] MAKEUP_RST   = 30'd268435456;

    localparam logic [31:0] LIMIT_LEVEL    = 32'd1800000000;
    localparam logic [30:0] CLIP_KNEE      = 31'd1610612735;
    localparam int          CLIP_SPAN_LOG2 = 29;

    typedef struct packed {
        logic        start;
        logic        comp;
        logic [2:0]  band_en;
        logic [28:0] pre_gain;
    } t_lane_ctl;

    typedef struct packed {
        logic               we;
        logic [3:0]         idx;
        logic signed [31:0] value;
    } t_coef_wr;

endpackage

/* hdl/eqlim_if.sv */
// valid/ready channel interfaces for sample and result transactions
interface eqlim_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [31:0] left_in;
    logic signed [31:0] right_in;
    logic [3:0]         coeff_index;
    logic signed [31:0] coeff_value;

    modport source (output valid, op, left_in, right_in, coeff_index, coeff_value,
                    input ready);
    modport sink (input valid, op, left_in, right_in, coeff_index, coeff_value,
                  output ready);
endinterface

interface eqlim_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] left_out;
    logic signed [31:0] right_out;

    modport source (output valid, left_out, right_out, input ready);
    modport sink (input valid, left_out, right_out, output ready);
endinterface

/* hdl/stereo_three_band_eq_limiter.sv */
// top level of the stereo three-band equalizer with limiter and soft clip
//
// i_in carries one transaction per item: op selects a sample pair, a
// coefficient write or a history/envelope clear. Writes and clears complete
// in the accepting cycle and give no result. A sample pair gives exactly one
// o_out transaction. Configuration is written through i_cfg_we/idx/data.
// One pair is worked on at a time; i_in.ready stays low until its result
// has moved into the output register and rises in the next cycle.
// With no band enabled the pair skips the lanes and the merging stage
// passes it to o_out unchanged. Otherwise the two channel lanes run side by
// side, each sequencing its biquad products through one multiplier: a
// pre-scale when the compressor is on, then every enabled band that is not
// bypassed, the others being skipped. The merging stage then, with the
// compressor on, tracks the envelope, divides out the limiter gain when the
// envelope exceeds the limit and applies makeup gain; last it runs the soft
// clip divider. A synchronous low i_rst_n restores coefficients and
// configuration, clears history and envelope, and holds i_in.ready low.
// When o_out.ready is low the result waits in the output register and the
// next pair is processed behind it.
module stereo_three_band_eq_limiter import eqlim_pkg::*; #(
    parameter int FRAC_BITS = 28,
    parameter int NUM_BANDS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    eqlim_in_if.sink    i_in,
    eqlim_out_if.source o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [29:0] i_cfg_data
);
    logic [2:0]         r_band_en;
    logic               r_comp;
    logic [28:0]        r_pre;
    logic [29:0]        r_mkup;
    logic               r_busy;
    logic               r_ovalid;
    logic signed [31:0] r_ol;
    logic signed [31:0] r_or;

    logic               acc;
    logic               is_sample;
    logic               pass;
    t_lane_ctl          lane_ctl;
    t_coef_wr           coef_wr;
    logic               clr;
    logic               done_l;
    logic               done_r;
    logic signed [31:0] y_l;
    logic signed [31:0] y_r;
    logic               m_start;
    logic               m_valid;
    logic signed [31:0] m_l;
    logic signed [31:0] m_r;
    logic               take;

    assign i_in.ready = i_rst_n && !r_busy;
    assign acc        = i_in.valid && i_in.ready;
    assign is_sample  = acc && (i_in.op == OP_SAMPLE);
    assign pass       = (r_band_en == 3'd0);
    assign clr        = acc && (i_in.op == OP_CLEAR);

    assign lane_ctl.start    = is_sample && !pass;
    assign lane_ctl.comp     = r_comp;
    assign lane_ctl.band_en  = r_band_en;
    assign lane_ctl.pre_gain = r_pre;

    assign coef_wr.we    = acc && (i_in.op == OP_COEF);
    assign coef_wr.idx   = i_in.coeff_index;
    assign coef_wr.value = i_in.coeff_value;

    eqlim_lane #(.FRAC_BITS(FRAC_BITS), .NUM_BANDS(NUM_BANDS)) u_lane_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (lane_ctl),
        .i_x     (i_in.left_in),
        .i_wr    (coef_wr),
        .i_clear (clr),
        .o_done  (done_l),
        .o_y     (y_l)
    );

    eqlim_lane #(.FRAC_BITS(FRAC_BITS), .NUM_BANDS(NUM_BANDS)) u_lane_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (lane_ctl),
        .i_x     (i_in.right_in),
        .i_wr    (coef_wr),
        .i_clear (clr),
        .o_done  (done_r),
        .o_y     (y_r)
    );

    assign m_start = (is_sample && pass) || done_l;
    assign take    = m_valid && (!r_ovalid || o_out.ready);

    eqlim_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (m_start),
        .i_pass   (pass),
        .i_comp   (r_comp),
        .i_makeup (r_mkup),
        .i_l      (done_l ? y_l : i_in.left_in),
        .i_r      (done_l ? y_r : i_in.right_in),
        .i_clear  (clr),
        .i_take   (take),
        .o_valid  (m_valid),
        .o_l      (m_l),
        .o_r      (m_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_en <= '0;
            r_comp    <= 1'b0;
            r_pre     <= PRE_GAIN_RST;
            r_mkup    <= MAKEUP_RST;
            r_busy    <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BAND_EN:  r_band_en <= i_cfg_data[2:0];
                    CFG_COMP_EN:  r_comp    <= i_cfg_data[0];
                    CFG_PRE_GAIN: r_pre     <= i_cfg_data[28:0];
                    CFG_MAKEUP:   r_mkup    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (is_sample) begin
                r_busy <= 1'b1;
            end else if (take) begin
                r_busy <= 1'b0;
            end
            if (take) begin
                r_ovalid <= 1'b1;
                r_ol     <= m_l;
                r_or     <= m_r;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.left_out  = r_ol;
    assign o_out.right_out = r_or;

`ifndef NO_ASSERTIONS
    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_l == done_r)
        else $error("channel lanes finished in different cycles");

    a_busy_after_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_sample |=> r_busy)
        else $error("sample transaction did not mark the block busy");

    a_free_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> !r_busy && r_ovalid)
        else $error("result moved out but block stayed busy");

    a_merge_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_valid || done_l) |-> r_busy)
        else $error("result produced with no sample in flight");
`endif
endmodule

/* hdl/eqlim_div.sv */
// iterative restoring divider, one quotient bit per cycle
module eqlim_div #(
    parameter int DW = 32,
    parameter int QW = 28
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_rem,
    input  logic [DW-1:0] i_den,
    output logic          o_busy,
    output logic [QW-1:0] o_quo
);
    localparam int CW = $clog2(QW + 1);

    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [QW-1:0] r_q;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [DW:0]   sft;
    logic [DW:0]   dif;
    logic          ge;

    assign sft = {r_rem, 1'b0};
    assign dif = sft - {1'b0, r_den};
    assign ge  = sft >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_rem  <= i_rem;
            r_den  <= i_den;
            r_q    <= '0;
            r_cnt  <= CW'(QW);
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_rem <= ge ? dif[DW-1:0] : sft[DW-1:0];
            r_q   <= {r_q[QW-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_q;
endmodule

/* hdl/eqlim_lane.sv */
// one channel lane: pre-scale (with the compressor on) and biquad cascade on a shared multiplier
module eqlim_lane import eqlim_pkg::*; #(
    parameter int FRAC_BITS = 28,
    parameter int NUM_BANDS = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_lane_ctl          i_ctl,
    input  logic signed [31:0] i_x,
    input  t_coef_wr           i_wr,
    input  logic               i_clear,
    output logic               o_done,
    output logic signed [31:0] o_y
);
    localparam int NB_EFF = (NUM_BANDS < 3) ? NUM_BANDS : 3;
    localparam int BW     = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int CW     = $clog2(NB_EFF + 1);
    localparam int AW     = 68;

    typedef enum logic [2:0] {
        S_IDLE, S_PRE, S_NEXT, S_ISSUE, S_DRAIN, S_FIN, S_DONE
    } t_state;

    t_state             r_state;
    logic signed [31:0] r_v;
    logic [CW-1:0]      r_band;
    logic [2:0]         r_k;
    logic               r_cnt;
    logic               r_pre;
    logic [2:0]         r_ben;
    logic [28:0]        r_gain;

    logic signed [31:0] r_cb0 [NUM_BANDS];
    logic signed [31:0] r_cb1 [NUM_BANDS];
    logic signed [31:0] r_cb2 [NUM_BANDS];
    logic signed [31:0] r_ca1 [NUM_BANDS];
    logic signed [31:0] r_ca2 [NUM_BANDS];
    logic signed [31:0] r_hx1 [NUM_BANDS];
    logic signed [31:0] r_hx2 [NUM_BANDS];
    logic signed [31:0] r_hy1 [NUM_BANDS];
    logic signed [31:0] r_hy2 [NUM_BANDS];

    logic               r_s1v;
    logic               r_s1n;
    logic signed [31:0] r_ma;
    logic signed [32:0] r_mb;
    logic               r_s2v;
    logic               r_s2n;
    logic signed [64:0] r_prod;
    logic signed [AW-1:0] r_acc;

    logic [BW-1:0]      bidx;
    logic [2:0]         ben_sh;
    logic               band_on;
    logic               bypass;
    logic signed [31:0] op_a;
    logic signed [32:0] op_b;
    logic               op_neg;
    logic signed [AW-1:0] acc_sh;
    logic signed [31:0] y_sat;

    always_comb begin
        bidx    = BW'(r_band);
        ben_sh  = r_ben >> r_band;
        band_on = ben_sh[0];
        bypass  = (r_cb1[bidx] == 32'sd0) && (r_ca1[bidx] == 32'sd0);
        op_neg  = 1'b0;
        case (r_k)
            3'd0: begin
                op_a = r_cb0[bidx];
                op_b = {r_v[31], r_v};
            end
            3'd1: begin
                op_a = r_cb1[bidx];
                op_b = {r_hx1[bidx][31], r_hx1[bidx]};
            end
            3'd2: begin
                op_a = r_cb2[bidx];
                op_b = {r_hx2[bidx][31], r_hx2[bidx]};
            end
            3'd3: begin
                op_a   = r_ca1[bidx];
                op_b   = {r_hy1[bidx][31], r_hy1[bidx]};
                op_neg = 1'b1;
            end
            3'd4: begin
                op_a   = r_ca2[bidx];
                op_b   = {r_hy2[bidx][31], r_hy2[bidx]};
                op_neg = 1'b1;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        acc_sh = r_acc >>> FRAC_BITS;
        if (acc_sh[AW-1] && !(&acc_sh[AW-2:31])) begin
            y_sat = 32'sh80000000;
        end else if (!acc_sh[AW-1] && (|acc_sh[AW-2:31])) begin
            y_sat = 32'sh7fffffff;
        end else begin
            y_sat = acc_sh[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_s1v   <= 1'b0;
            r_s2v   <= 1'b0;
            for (int b = 0; b < NUM_BANDS; b++) begin
                r_cb0[b] <= 32'sd1 <<< FRAC_BITS;
                r_cb1[b] <= '0;
                r_cb2[b] <= '0;
                r_ca1[b] <= '0;
                r_ca2[b] <= '0;
                r_hx1[b] <= '0;
                r_hx2[b] <= '0;
                r_hy1[b] <= '0;
                r_hy2[b] <= '0;
            end
        end else begin
            r_s1v  <= 1'b0;
            r_s2v  <= r_s1v;
            r_s2n  <= r_s1n;
            r_prod <= r_ma * r_mb;
            if (r_s2v) begin
                r_acc <= r_s2n ? r_acc - AW'(r_prod) : r_acc + AW'(r_prod);
            end

            for (int b = 0; b < NUM_BANDS; b++) begin
                if (i_wr.we && int'(i_wr.idx) == 5 * b)     r_cb0[b] <= i_wr.value;
                if (i_wr.we && int'(i_wr.idx) == 5 * b + 1) r_cb1[b] <= i_wr.value;
                if (i_wr.we && int'(i_wr.idx) == 5 * b + 2) r_cb2[b] <= i_wr.value;
                if (i_wr.we && int'(i_wr.idx) == 5 * b + 3) r_ca1[b] <= i_wr.value;
                if (i_wr.we && int'(i_wr.idx) == 5 * b + 4) r_ca2[b] <= i_wr.value;
                if (i_clear) begin
                    r_hx1[b] <= '0;
                    r_hx2[b] <= '0;
                    r_hy1[b] <= '0;
                    r_hy2[b] <= '0;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        r_v     <= i_x;
                        r_ben   <= i_ctl.band_en;
                        r_gain  <= i_ctl.pre_gain;
                        r_band  <= '0;
                        r_acc   <= '0;
                        r_state <= i_ctl.comp ? S_PRE : S_NEXT;
                    end
                end
                S_PRE: begin
                    r_s1v   <= 1'b1;
                    r_s1n   <= 1'b0;
                    r_ma    <= r_v;
                    r_mb    <= {4'd0, r_gain};
                    r_pre   <= 1'b1;
                    r_cnt   <= 1'b0;
                    r_state <= S_DRAIN;
                end
                S_NEXT: begin
                    if (r_band == CW'(NB_EFF)) begin
                        r_state <= S_DONE;
                    end else if (band_on && !bypass) begin
                        r_k     <= '0;
                        r_acc   <= '0;
                        r_pre   <= 1'b0;
                        r_state <= S_ISSUE;
                    end else begin
                        r_band <= r_band + 1'b1;
                    end
                end
                S_ISSUE: begin
                    r_s1v <= 1'b1;
                    r_s1n <= op_neg;
                    r_ma  <= op_a;
                    r_mb  <= op_b;
                    if (r_k == 3'd4) begin
                        r_cnt   <= 1'b0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (r_cnt) begin
                        r_state <= S_FIN;
                    end else begin
                        r_cnt <= 1'b1;
                    end
                end
                S_FIN: begin
                    r_v <= y_sat;
                    if (!r_pre) begin
                        r_hx2[bidx] <= r_hx1[bidx];
                        r_hx1[bidx] <= r_v;
                        r_hy2[bidx] <= r_hy1[bidx];
                        r_hy1[bidx] <= y_sat;
                        r_band      <= r_band + 1'b1;
                    end
                    r_state <= S_NEXT;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_state == S_DONE);
    assign o_y    = r_v;
endmodule

/* hdl/eqlim_merge.sv */
// merging stage: shared envelope, limiter and makeup gain when the compressor is on, then soft clip
module eqlim_merge import eqlim_pkg::*; #(
    parameter int FRAC_BITS = 28
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_pass,
    input  logic               i_comp,
    input  logic [29:0]        i_makeup,
    input  logic signed [31:0] i_l,
    input  logic signed [31:0] i_r,
    input  logic               i_clear,
    input  logic               i_take,
    output logic               o_valid,
    output logic signed [31:0] o_l,
    output logic signed [31:0] o_r
);
    localparam int OW = 63 - FRAC_BITS;
    localparam int DC = OW + 1;

    typedef enum logic [3:0] {
        M_IDLE, M_PEAK, M_ENV, M_LIM, M_DIVW, M_MULG, M_SHG,
        M_MULM, M_SHM, M_CLIP, M_CLIPW, M_HOLD
    } t_state;

    t_state                r_state;
    logic [31:0]           r_env;
    logic [31:0]           r_peak;
    logic [FRAC_BITS-1:0]  r_g;
    logic signed [31:0]    r_s [2];
    logic signed [62:0]    r_p [2];
    logic signed [OW-1:0]  r_o [2];
    logic [30:0]           r_ax [2];
    logic                  r_need [2];
    logic                  r_neg [2];
    logic signed [31:0]    r_out [2];

    logic signed [30:0]    mop;
    logic signed [62:0]    prod [2];
    logic signed [62:0]    psh [2];
    logic [31:0]           mag [2];
    logic [OW-1:0]         ax [2];
    logic                  need [2];
    logic [DC-1:0]         cl_rem [2];
    logic [DC-1:0]         cl_den [2];
    logic                  cl_busy [2];
    logic [CLIP_SPAN_LOG2-1:0] cl_q [2];
    logic [31:0]           y_mag [2];
    logic                  lim_start;
    logic                  lim_busy;
    logic [FRAC_BITS-1:0]  lim_q;
    logic                  clip_start;

    assign mop = (r_state == M_MULG) ? signed'({{(31 - FRAC_BITS){1'b0}}, r_g})
                                     : signed'({1'b0, i_makeup});
    assign lim_start  = (r_state == M_LIM) && (r_env > LIMIT_LEVEL);
    assign clip_start = (r_state == M_CLIP);

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            logic [32:0] sx;
            logic [32:0] sa;
            sx      = {r_s[c][31], r_s[c]};
            sa      = r_s[c][31] ? -sx : sx;
            mag[c]  = sa[31:0];
            prod[c] = r_s[c] * mop;
            psh[c]  = r_p[c] >>> FRAC_BITS;
            ax[c]   = r_o[c][OW-1] ? -r_o[c] : r_o[c];
            need[c] = ax[c] > OW'(CLIP_KNEE);
            cl_rem[c] = need[c] ? DC'(ax[c]) - DC'(CLIP_KNEE) : '0;
            cl_den[c] = cl_rem[c] + (DC'(1) << CLIP_SPAN_LOG2);
            y_mag[c]  = r_need[c] ? 32'(CLIP_KNEE) + 32'(cl_q[c]) : {1'b0, r_ax[c]};
        end
    end

    eqlim_div #(.DW(32), .QW(FRAC_BITS)) u_lim_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lim_start),
        .i_rem   (LIMIT_LEVEL),
        .i_den   (r_env),
        .o_busy  (lim_busy),
        .o_quo   (lim_q)
    );

    for (genvar c = 0; c < 2; c++) begin : g_clip
        eqlim_div #(.DW(DC), .QW(CLIP_SPAN_LOG2)) u_clip_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (clip_start),
            .i_rem   (cl_rem[c]),
            .i_den   (cl_den[c]),
            .o_busy  (cl_busy[c]),
            .o_quo   (cl_q[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_env   <= '0;
        end else begin
            if (i_clear) begin
                r_env <= '0;
            end
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_s[0] <= i_l;
                        r_s[1] <= i_r;
                        r_o[0] <= {{(OW - 32){i_l[31]}}, i_l};
                        r_o[1] <= {{(OW - 32){i_r[31]}}, i_r};
                        r_out[0] <= i_l;
                        r_out[1] <= i_r;
                        if (i_pass) begin
                            r_state <= M_HOLD;
                        end else if (i_comp) begin
                            r_state <= M_PEAK;
                        end else begin
                            r_state <= M_CLIP;
                        end
                    end
                end
                M_PEAK: begin
                    r_peak  <= (mag[0] > mag[1]) ? mag[0] : mag[1];
                    r_state <= M_ENV;
                end
                M_ENV: begin
                    if (r_peak > r_env) begin
                        r_env <= r_env + ((r_peak - r_env) >> 7);
                    end else begin
                        r_env <= r_env - (r_env >> 13);
                    end
                    r_state <= M_LIM;
                end
                M_LIM: begin
                    r_state <= lim_start ? M_DIVW : M_MULM;
                end
                M_DIVW: begin
                    if (!lim_busy) begin
                        r_g     <= lim_q;
                        r_state <= M_MULG;
                    end
                end
                M_MULG: begin
                    r_p[0]  <= prod[0];
                    r_p[1]  <= prod[1];
                    r_state <= M_SHG;
                end
                M_SHG: begin
                    r_s[0]  <= psh[0][31:0];
                    r_s[1]  <= psh[1][31:0];
                    r_state <= M_MULM;
                end
                M_MULM: begin
                    r_p[0]  <= prod[0];
                    r_p[1]  <= prod[1];
                    r_state <= M_SHM;
                end
                M_SHM: begin
                    r_o[0]  <= psh[0][OW-1:0];
                    r_o[1]  <= psh[1][OW-1:0];
                    r_state <= M_CLIP;
                end
                M_CLIP: begin
                    for (int c = 0; c < 2; c++) begin
                        r_ax[c]   <= ax[c][30:0];
                        r_need[c] <= need[c];
                        r_neg[c]  <= r_o[c][OW-1];
                    end
                    r_state <= M_CLIPW;
                end
                M_CLIPW: begin
                    if (!cl_busy[0] && !cl_busy[1]) begin
                        for (int c = 0; c < 2; c++) begin
                            r_out[c] <= r_neg[c] ? -y_mag[c] : y_mag[c];
                        end
                        r_state <= M_HOLD;
                    end
                end
                M_HOLD: begin
                    if (i_take) begin
                        r_state <= M_IDLE;
                    end
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_valid = (r_state == M_HOLD);
    assign o_l     = r_out[0];
    assign o_r     = r_out[1];
endmodule
